// ===== rtl/core/nst_pkg.sv =====
// package for the named semaphore table unit
// shared types, codes and sizes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nst_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int NAME_W         = 8;
    localparam int INDEX_W        = 8;
    localparam int COUNT_W        = 16;
    localparam int ENTRY_W        = NAME_W + COUNT_W;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic [NAME_W-1:0]  name_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [1:0] {
        OP_OPEN   = 2'd0,
        OP_WAIT   = 2'd1,
        OP_POST   = 2'd2,
        OP_UNLINK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_INVALID  = 3'd2,
        ST_BLOCK    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        op_t    op;
        name_t  name;
        index_t target;
        count_t init;
        logic   target_ok;
    } cmd_t;

    typedef struct packed {
        status_t status;
        index_t  index;
        count_t  count;
        logic    wake;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/named_semaphore_table_unit.sv =====
// top level of the named semaphore table unit
// depends on nst_pkg, nst_front and nst_back
//
// channel   direction  tvalid/tready   payload
// s_axis    in         accept on both  tuser: opcode; tdata: name, target, initial count
// m_axis    out        accept on both  tuser: status; tdata: index, count, wake
//
// open and unlink walk the slot memory one read per cycle
// wait and post pass fetch and execute; an invalid slot number goes straight to result
// reset clears per-slot valid flags at once, no clearing pass
// a two-entry queue accepts until full while the back end works or its result waits
`timescale 1ns / 1ps
`default_nettype none

module named_semaphore_table_unit #(
    parameter int SLOT_COUNT = nst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // name_char, target_index, initial_count
    input  wire logic [1:0]  s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // result_index, count_value, wake_waiters
    output logic [2:0]       m_axis_tuser    // status
);

    logic          head_valid;
    nst_pkg::cmd_t head;
    logic          pop;
    nst_pkg::res_t res;

    nst_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_name    (s_axis_tdata[7:0]),
        .in_target  (s_axis_tdata[15:8]),
        .in_init    (s_axis_tdata[31:16]),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    nst_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head),
        .cmd_pop   (pop),
        .res_valid (m_axis_tvalid),
        .res       (res),
        .res_ready (m_axis_tready)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {7'd0, res.wake, res.count, res.index};

endmodule

`default_nettype wire

// ===== rtl/core/nst_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nst_front.sv =====
// front end: accepts operations, classifies them and queues them for the back end
// depends on nst_pkg
`timescale 1ns / 1ps
`default_nettype none

module nst_front #(
    parameter int SLOT_COUNT = nst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     in_op,
    input  wire nst_pkg::name_t  in_name,
    input  wire nst_pkg::index_t in_target,
    input  wire nst_pkg::count_t in_init,
    output logic                head_valid,
    output nst_pkg::cmd_t       head,
    input  wire logic           pop
);

    localparam int QD   = nst_pkg::QUEUE_DEPTH;
    localparam int PW   = (QD > 1) ? $clog2(QD) : 1;
    localparam int FW   = $clog2(QD + 1);

    nst_pkg::cmd_t  entries_reg [QD];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]  fill_reg, fill_next;
    nst_pkg::cmd_t  cmd_in;
    logic           push;

    always_comb
    begin
        cmd_in.op        = nst_pkg::op_t'(in_op);
        cmd_in.name      = in_name;
        cmd_in.target    = in_target;
        cmd_in.init      = in_init;
        cmd_in.target_ok = (in_target != '0) && (int'(in_target) < SLOT_COUNT);
    end

    assign in_ready   = (fill_reg != FW'(QD));
    assign push       = in_valid && in_ready;
    assign head_valid = (fill_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nst_back.sv =====
// back end: carries out queued operations on the slot table and holds the result
// depends on nst_pkg and nst_ram
`timescale 1ns / 1ps
`default_nettype none

module nst_back #(
    parameter int SLOT_COUNT = nst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire nst_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               res_valid,
    output nst_pkg::res_t      res,
    input  wire logic          res_ready
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NW    = nst_pkg::NAME_W;
    localparam int CW    = nst_pkg::COUNT_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_FETCH  = 5'b00100,
        S_EXEC   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    nst_pkg::cmd_t           cmd_reg, cmd_next;
    logic [IDX_W-1:0]        addr_reg, addr_next;
    logic                    issuing_reg, issuing_next;
    logic                    cmp_live_reg, cmp_live_next;
    logic [IDX_W-1:0]        cmp_addr_reg, cmp_addr_next;
    logic [IDX_W-1:0]        empty_reg, empty_next;
    logic                    has_empty_reg, has_empty_next;
    nst_pkg::res_t           res_reg, res_next;
    logic [SLOT_COUNT-1:0]   valid_reg, valid_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    out_valid_reg, out_valid_next;
    nst_pkg::res_t           out_reg, out_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    nst_pkg::entry_t         ram_wdata;
    nst_pkg::entry_t         ram_rdata;
    nst_pkg::name_t          entry_name;
    nst_pkg::count_t         entry_count;
    logic                    empty_hit;

    nst_ram #(
        .WIDTH (nst_pkg::ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // slot never written reads as empty with zero count
    assign entry_name  = rd_valid_reg ? ram_rdata[NW+CW-1:CW] : '0;
    assign entry_count = rd_valid_reg ? ram_rdata[CW-1:0] : '0;
    assign empty_hit   = (entry_name == '0);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        issuing_next   = issuing_reg;
        cmp_live_next  = 1'b0;
        cmp_addr_next  = addr_reg;
        empty_next     = empty_reg;
        has_empty_next = has_empty_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        rd_valid_next  = valid_reg[addr_reg];
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop        = 1'b1;
                    cmd_next       = cmd;
                    issuing_next   = 1'b0;
                    has_empty_next = 1'b0;
                    if (cmd.op inside {nst_pkg::OP_OPEN, nst_pkg::OP_UNLINK})
                    begin
                        addr_next    = IDX_W'(1);
                        issuing_next = 1'b1;
                        state_next   = S_SCAN;
                    end
                    else if (cmd.target_ok)
                    begin
                        addr_next  = cmd.target[IDX_W-1:0];
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        res_next.status = nst_pkg::ST_INVALID;
                        res_next.index  = cmd.target;
                        res_next.count  = '0;
                        res_next.wake   = 1'b0;
                        state_next      = S_RESULT;
                    end
                end
            end

            S_SCAN:
            begin
                // one slot read issued and one compared per cycle
                cmp_live_next = issuing_reg;
                cmp_addr_next = addr_reg;
                if (issuing_reg)
                begin
                    if (addr_reg == LAST)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                if (cmp_live_reg)
                begin
                    res_next.wake = 1'b0;
                    if (cmd_reg.op == nst_pkg::OP_OPEN)
                    begin
                        if (!empty_hit && entry_name == cmd_reg.name)
                        begin
                            res_next.status = nst_pkg::ST_OK;
                            res_next.index  = nst_pkg::index_t'(cmp_addr_reg);
                            res_next.count  = entry_count;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            if (empty_hit)
                            begin
                                empty_next     = cmp_addr_reg;
                                has_empty_next = 1'b1;
                            end
                            if (cmp_addr_reg == LAST)
                            begin
                                if (empty_hit || has_empty_reg)
                                begin
                                    ram_we          = 1'b1;
                                    ram_waddr       = empty_hit ? cmp_addr_reg : empty_reg;
                                    ram_wdata       = {cmd_reg.name, cmd_reg.init};
                                    res_next.status = nst_pkg::ST_OK;
                                    res_next.index  = nst_pkg::index_t'(ram_waddr);
                                    res_next.count  = cmd_reg.init;
                                end
                                else
                                begin
                                    res_next.status = nst_pkg::ST_FULL;
                                    res_next.index  = '0;
                                    res_next.count  = '0;
                                end
                                state_next = S_RESULT;
                            end
                        end
                    end
                    else
                    begin
                        if (entry_name == cmd_reg.name)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = cmp_addr_reg;
                            ram_wdata       = '0;
                            res_next.status = nst_pkg::ST_OK;
                            res_next.index  = nst_pkg::index_t'(cmp_addr_reg);
                            res_next.count  = '0;
                            state_next      = S_RESULT;
                        end
                        else if (cmp_addr_reg == LAST)
                        begin
                            res_next.status = nst_pkg::ST_NOTFOUND;
                            res_next.index  = '0;
                            res_next.count  = '0;
                            state_next      = S_RESULT;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                res_next.index = cmd_reg.target;
                res_next.wake  = 1'b0;
                state_next     = S_RESULT;
                if (empty_hit)
                begin
                    res_next.status = nst_pkg::ST_INVALID;
                    res_next.count  = '0;
                end
                else if (cmd_reg.op == nst_pkg::OP_WAIT)
                begin
                    if (entry_count == '0)
                    begin
                        res_next.status = nst_pkg::ST_BLOCK;
                        res_next.count  = '0;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = {entry_name, entry_count - 1'b1};
                        res_next.status = nst_pkg::ST_OK;
                        res_next.count  = entry_count - 1'b1;
                    end
                end
                else
                begin
                    // saturating increment
                    ram_we          = 1'b1;
                    ram_wdata[NW+CW-1:CW] = entry_name;
                    ram_wdata[CW-1:0]     = (&entry_count) ? entry_count
                                                           : entry_count + 1'b1;
                    res_next.status = nst_pkg::ST_OK;
                    res_next.count  = ram_wdata[CW-1:0];
                    res_next.wake   = 1'b1;
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issuing_reg   <= 1'b0;
            cmp_live_reg  <= 1'b0;
            has_empty_reg <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issuing_reg   <= issuing_next;
            cmp_live_reg  <= cmp_live_next;
            has_empty_reg <= has_empty_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        cmp_addr_reg <= cmp_addr_next;
        empty_reg    <= empty_next;
        res_reg      <= res_next;
        rd_valid_reg <= rd_valid_next;
        out_reg      <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

`ifndef SYNTHESIS
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SCAN || state_reg == S_EXEC))
        else $error("slot write outside scan or execute");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE && cmd_valid))
        else $error("queue pop while busy");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cmp_live_reg && cmp_addr_reg == LAST)
            |=> (state_reg == S_RESULT))
        else $error("scan ran past the last slot");

    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res.wake || res.status == nst_pkg::ST_OK))
        else $error("wake on a failed operation");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for named_semaphore_table_unit
// predicts every result from a local copy of the slot table and checks the output stream
// depends on nst_pkg and the rtl of named_semaphore_table_unit
`timescale 1ns / 1ps

module testbench;

    import nst_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int RAND_ITEMS  = 1000;
    localparam int CALM_TAIL   = 150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = SLOTS + 20;

    typedef struct packed {
        op_t    op;
        name_t  nm;
        index_t tgt;
        count_t init;
    } sem_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // name_char, target_index, initial_count
    logic [1:0]  s_axis_tuser = '0;  // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // result_index, count_value, wake_waiters
    logic [2:0]  m_axis_tuser;       // status

    name_t    sem_name [SLOTS];
    count_t   sem_count[SLOTS];
    sem_req_t req_q[$];
    res_t     result_q[$];
    name_t    name_pool[$];

    int in_count   = 0;
    int out_count  = 0;
    int issued     = 0;
    int errors     = 0;
    int quiet      = 0;
    int calm_from  = 1 << 30;
    int snd_idle   = 0;
    int rcv_idle   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    res_t got;
    res_t want;

    named_semaphore_table_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // semaphore table behavior, updates the local table and returns the answer
    function automatic res_t apply_sem_op(op_t op, name_t nm, index_t tgt, count_t init);
        res_t r;
        int   empty;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_OPEN:
            begin
                empty = 0;
                for (int i = 1; i < SLOTS; i++)
                begin
                    if (sem_name[i] == '0)
                        empty = i;
                    else if (sem_name[i] == nm)
                    begin
                        r.index = index_t'(i);
                        r.count = sem_count[i];
                        return r;
                    end
                end
                if (empty == 0)
                begin
                    r.status = ST_FULL;
                    return r;
                end
                // name 0 keeps the slot empty but still sets its count
                sem_name[empty]  = nm;
                sem_count[empty] = init;
                r.index = index_t'(empty);
                r.count = init;
            end
            OP_WAIT, OP_POST:
            begin
                r.index = tgt;
                if (tgt == '0 || int'(tgt) >= SLOTS || sem_name[tgt] == '0)
                    r.status = ST_INVALID;
                else if (op == OP_WAIT)
                begin
                    if (sem_count[tgt] == '0)
                        r.status = ST_BLOCK;
                    else
                    begin
                        sem_count[tgt] = sem_count[tgt] - 1'b1;
                        r.count = sem_count[tgt];
                    end
                end
                else
                begin
                    if (sem_count[tgt] != '1)
                        sem_count[tgt] = sem_count[tgt] + 1'b1;
                    r.count = sem_count[tgt];
                    r.wake  = 1'b1;
                end
            end
            default:
            begin
                // name 0 matches the lowest empty slot
                for (int i = 1; i < SLOTS; i++)
                begin
                    if (sem_name[i] == nm)
                    begin
                        sem_name[i]  = '0;
                        sem_count[i] = '0;
                        r.index = index_t'(i);
                        return r;
                    end
                end
                r.status = ST_NOTFOUND;
            end
        endcase
        return r;
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic push_req(op_t op, name_t nm, index_t tgt, count_t init);
        sem_req_t q;
        q.op   = op;
        q.nm   = nm;
        q.tgt  = tgt;
        q.init = init;
        req_q.push_back(q);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
    endtask

    // prediction, checking and watchdog on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_q.push_back(apply_sem_op(op_t'(s_axis_tuser), s_axis_tdata[7:0],
                                                s_axis_tdata[15:8], s_axis_tdata[31:16]));
                in_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = status_t'(m_axis_tuser);
                got.index  = m_axis_tdata[7:0];
                got.count  = m_axis_tdata[23:8];
                got.wake   = m_axis_tdata[24];
                if (result_q.size() == 0)
                    flag_error($sformatf("unexpected result st=%0d idx=%0d cnt=%0d wake=%0d",
                                         got.status, got.index, got.count, got.wake));
                else
                begin
                    want = result_q.pop_front();
                    if (got.status !== want.status || got.index !== want.index
                        || got.count !== want.count || got.wake !== want.wake)
                        flag_error($sformatf({"result %0d: expected st=%0d idx=%0d cnt=%0d ",
                                              "wake=%0d, got st=%0d idx=%0d cnt=%0d wake=%0d"},
                                             out_count, want.status, want.index, want.count,
                                             want.wake, got.status, got.index, got.count,
                                             got.wake));
                end
                out_count++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && in_count < issued))
        begin
            if (snd_idle > 0)
            begin
                snd_idle--;
                s_axis_tvalid <= 1'b0;
            end
            else if (in_count < calm_from && $urandom_range(0, 9) == 0)
            begin
                snd_idle = $urandom_range(1, 19) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                sem_req_t q;
                q = req_q.pop_front();
                s_axis_tuser  <= q.op;
                s_axis_tdata  <= {q.init, q.tgt, q.nm};
                s_axis_tvalid <= 1'b1;
                issued++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // one long result back-pressure stretch
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && in_count >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result ready driver
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
            m_axis_tready <= 1'b0;
        else if (rcv_idle > 0)
        begin
            rcv_idle--;
            m_axis_tready <= 1'b0;
        end
        else if (in_count < calm_from && $urandom_range(0, 7) == 0)
        begin
            rcv_idle = $urandom_range(1, 19) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        op_t    op;
        name_t  nm;
        index_t tgt;
        count_t init;
        int     roll;

        for (int i = 0; i < SLOTS; i++)
        begin
            sem_name[i]  = '0;
            sem_count[i] = '0;
        end

        // directed: error paths, block, saturation, name zero, lookup and unlink
        push_req(OP_WAIT,   8'h00, 8'd5,   16'h0000);
        push_req(OP_POST,   8'h00, 8'd0,   16'h0000);
        push_req(OP_WAIT,   8'h00, 8'd255, 16'hFFFF);
        push_req(OP_UNLINK, 8'h41, 8'd0,   16'h0000);
        push_req(OP_OPEN,   8'h41, 8'd0,   16'h0000);
        push_req(OP_WAIT,   8'h00, 8'd63,  16'h0000);
        push_req(OP_POST,   8'h00, 8'd63,  16'h0000);
        push_req(OP_WAIT,   8'h00, 8'd63,  16'h0000);
        push_req(OP_OPEN,   8'h42, 8'd0,   16'hFFFF);
        push_req(OP_POST,   8'h00, 8'd62,  16'h0000);
        push_req(OP_WAIT,   8'h00, 8'd62,  16'h0000);
        push_req(OP_OPEN,   8'h41, 8'd0,   16'd7);
        push_req(OP_OPEN,   8'h00, 8'd0,   16'd1234);
        push_req(OP_WAIT,   8'h00, 8'd61,  16'h0000);
        push_req(OP_UNLINK, 8'h00, 8'd0,   16'h0000);
        push_req(OP_OPEN,   8'hFF, 8'hFF,  16'hFFFF);
        push_req(OP_POST,   8'h00, 8'd64,  16'h0000);
        push_req(OP_POST,   8'h00, 8'h80,  16'h0000);
        push_req(OP_UNLINK, 8'h42, 8'd0,   16'h0000);
        push_req(OP_UNLINK, 8'h42, 8'd0,   16'h0000);
        push_req(OP_OPEN,   8'hFF, 8'd0,   16'h0000);
        push_req(OP_UNLINK, 8'hFF, 8'd0,   16'h0000);
        push_req(OP_UNLINK, 8'h41, 8'd0,   16'h0000);
        push_req(OP_OPEN,   8'h55, 8'h55,  16'hAAAA);
        push_req(OP_WAIT,   8'hAA, 8'hAA,  16'h5555);
        calm_from = req_q.size() + RAND_ITEMS - CALM_TAIL;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait_drained();

        // segments: mixed, fill, mixed, drain, ...
        for (int s = 0; s < RAND_ITEMS / 100; s++)
        begin
            if (s == 6)
                wait_drained();
            for (int k = 0; k < 100; k++)
            begin
                roll = $urandom_range(0, 99);
                case (s % 4)
                    1:       op = (roll < 80) ? OP_OPEN : op_t'($urandom_range(1, 3));
                    3:       op = (roll < 75) ? OP_UNLINK : op_t'($urandom_range(0, 2));
                    default: op = op_t'($urandom_range(0, 3));
                endcase
                if ((s % 4 == 1 && op == OP_OPEN) || name_pool.size() == 0
                    || $urandom_range(0, 9) < 3)
                    nm = name_t'($urandom_range(0, 255));
                else
                    nm = name_pool[$urandom_range(0, name_pool.size() - 1)];
                if (op == OP_OPEN && nm != '0)
                    name_pool.push_back(nm);

                roll = $urandom_range(0, 19);
                if (roll == 0)
                    tgt = '0;
                else if (roll == 1)
                    tgt = index_t'($urandom_range(SLOTS, 255));
                else
                    tgt = index_t'($urandom_range(1, SLOTS - 1));

                roll = $urandom_range(0, 7);
                if (roll < 2)
                    init = '0;
                else if (roll == 2)
                    init = '1;
                else if (roll < 5)
                    init = count_t'($urandom_range(1, 3));
                else
                    init = count_t'($urandom_range(0, 65535));

                push_req(op, nm, tgt, init);
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
